// File: src/rms_pkg.sv
// Shared types and constants for the register machine step block.
package rms_pkg;

   localparam int NUM_VARS   = 128;
   localparam int NUM_LINES  = 1024;
   localparam int DATA_WIDTH = 32;

   localparam int VAR_AW  = $clog2(NUM_VARS);
   localparam int LINE_W  = $clog2(NUM_LINES);
   localparam int CNT_W   = $clog2(DATA_WIDTH + 1);

   // item kinds
   localparam logic [1:0] KIND_WR_VAR  = 2'd0;
   localparam logic [1:0] KIND_WR_INS  = 2'd1;
   localparam logic [1:0] KIND_STEP    = 2'd2;
   localparam logic [1:0] KIND_RESTART = 2'd3;

   // opcodes
   localparam logic [2:0] OP_STOP   = 3'd0;
   localparam logic [2:0] OP_BRANCH = 3'd1;
   localparam logic [2:0] OP_JUMP   = 3'd2;
   localparam logic [2:0] OP_PRINT  = 3'd3;
   localparam logic [2:0] OP_ASSIGN = 3'd4;

   // operation selectors
   localparam logic [3:0] SEL_ADD = 4'd0;
   localparam logic [3:0] SEL_SUB = 4'd1;
   localparam logic [3:0] SEL_MUL = 4'd2;
   localparam logic [3:0] SEL_DIV = 4'd3;
   localparam logic [3:0] SEL_MOD = 4'd4;
   localparam logic [3:0] SEL_EQ  = 4'd5;
   localparam logic [3:0] SEL_NE  = 4'd6;
   localparam logic [3:0] SEL_LT  = 4'd7;
   localparam logic [3:0] SEL_GT  = 4'd8;
   localparam logic [3:0] SEL_LE  = 4'd9;
   localparam logic [3:0] SEL_GE  = 4'd10;

   // result status
   localparam logic [1:0] ST_NONE  = 2'd0;
   localparam logic [1:0] ST_PRINT = 2'd1;
   localparam logic [1:0] ST_HALT  = 2'd2;
   localparam logic [1:0] ST_ERROR = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [9:0]         index;
      logic signed [31:0] value;
      logic [2:0]         opcode;
      logic [3:0]         op_select;
      logic [6:0]         src_a;
      logic [6:0]         src_b;
      logic [6:0]         dest_var;
      logic [9:0]         jump_line;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] print_value;
      logic [9:0]         exec_line;
   } rsp_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [3:0] op_select;
      logic [6:0] src_a;
      logic [6:0] src_b;
      logic [6:0] dest_var;
      logic [9:0] jump_line;
   } prog_word_type;

endpackage

// File: src/register_machine_step.sv
// Stepped stored-program machine: variable file, program store, shared ALU and divider.
// Loads and restart are taken in the idle state; the block stays ready after them.
// Step path: halted goes straight to the result; stop and jump decode; print also reads;
// branch reads, compares; add, sub, mul also write back; div, mod use the 32-step divider
// first; zero divisor halts with error. Ready once result is valid; a held result stalls it.
// Reset (sync, active high): line 1, halt cleared, no result; memories keep contents.
module register_machine_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rms_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rms_pkg::rsp_type rsp_data
);
   import rms_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DEC  = 4'd1;
   localparam logic [3:0] S_RDB  = 4'd2;
   localparam logic [3:0] S_OPS  = 4'd3;
   localparam logic [3:0] S_DIV  = 4'd4;
   localparam logic [3:0] S_WB   = 4'd5;
   localparam logic [3:0] S_FIN  = 4'd6;

   logic [DATA_WIDTH-1:0] var_mem [NUM_VARS];
   prog_word_type         prog_mem [NUM_LINES];

   logic [3:0]            state_ff, state_in;
   logic [LINE_W-1:0]     pc_ff, pc_in;
   logic                  halted_ff, halted_in;
   logic [DATA_WIDTH-1:0] x_ff, x_in;
   logic [DATA_WIDTH-1:0] res_ff, res_in;
   logic                  wr_en_ff, wr_en_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] divisor_ff, divisor_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [1:0]            pend_status_ff, pend_status_in;
   logic [31:0]           pend_pv_ff, pend_pv_in;
   logic [LINE_W-1:0]     pend_line_ff, pend_line_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   prog_word_type         prog_rdata_ff;
   logic [DATA_WIDTH-1:0] var_rdata_ff;

   logic                  var_we;
   logic [VAR_AW-1:0]     var_waddr, var_raddr;
   logic [DATA_WIDTH-1:0] var_wdata;
   logic                  prog_we;

   logic                  req_xfer;
   logic                  cmp_true;
   logic [DATA_WIDTH-1:0] y_val, mag_x, mag_y;
   logic [DATA_WIDTH:0]   rem_sh, diff;
   logic [DATA_WIDTH-1:0] div_out;

   // memories: one write and one registered read port each
   always_ff @(posedge clock) begin
      if (var_we) begin
         var_mem[var_waddr] <= var_wdata;
      end
      var_rdata_ff <= var_mem[var_raddr];
   end

   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[req_data.index[LINE_W-1:0]] <= '{
            opcode:    req_data.opcode,
            op_select: req_data.op_select,
            src_a:     req_data.src_a,
            src_b:     req_data.src_b,
            dest_var:  req_data.dest_var,
            jump_line: req_data.jump_line};
      end
      prog_rdata_ff <= prog_mem[pc_ff];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign y_val = var_rdata_ff;
   assign mag_x = x_ff[DATA_WIDTH-1] ? (~x_ff + 1'b1) : x_ff;
   assign mag_y = y_val[DATA_WIDTH-1] ? (~y_val + 1'b1) : y_val;

   always_comb begin
      case (prog_rdata_ff.op_select)
         SEL_EQ:  cmp_true = ($signed(x_ff) == $signed(y_val));
         SEL_NE:  cmp_true = ($signed(x_ff) != $signed(y_val));
         SEL_LT:  cmp_true = ($signed(x_ff) <  $signed(y_val));
         SEL_GT:  cmp_true = ($signed(x_ff) >  $signed(y_val));
         SEL_LE:  cmp_true = ($signed(x_ff) <= $signed(y_val));
         SEL_GE:  cmp_true = ($signed(x_ff) >= $signed(y_val));
         default: cmp_true = 1'b0;
      endcase
   end

   // restoring divider step
   assign rem_sh  = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign diff    = rem_sh - {1'b0, divisor_ff};
   assign div_out = (prog_rdata_ff.op_select == SEL_MOD) ? rem_ff : quo_ff;

   always_comb begin
      state_in       = state_ff;
      pc_in          = pc_ff;
      halted_in      = halted_ff;
      x_in           = x_ff;
      res_in         = res_ff;
      wr_en_in       = wr_en_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      divisor_in     = divisor_ff;
      cnt_in         = cnt_ff;
      neg_in         = neg_ff;
      pend_status_in = pend_status_ff;
      pend_pv_in     = pend_pv_ff;
      pend_line_in   = pend_line_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      var_we         = 1'b0;
      var_waddr      = req_data.index[VAR_AW-1:0];
      var_wdata      = req_data.value;
      var_raddr      = prog_rdata_ff.src_a;
      prog_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_data.kind)
                  KIND_WR_VAR: begin
                     var_we = (req_data.index < 10'(NUM_VARS));
                  end
                  KIND_WR_INS: begin
                     prog_we = (32'(req_data.index) < NUM_LINES);
                  end
                  KIND_RESTART: begin
                     pc_in     = LINE_W'(1);
                     halted_in = 1'b0;
                  end
                  default: begin
                     pend_line_in = pc_ff;
                     pend_pv_in   = '0;
                     if (halted_ff) begin
                        pend_status_in = ST_HALT;
                        state_in       = S_FIN;
                     end else begin
                        state_in = S_DEC;
                     end
                  end
               endcase
            end
         end
         S_DEC: begin
            pend_status_in = ST_NONE;
            var_raddr = (prog_rdata_ff.opcode == OP_PRINT) ? prog_rdata_ff.dest_var
                                                           : prog_rdata_ff.src_a;
            case (prog_rdata_ff.opcode)
               OP_JUMP: begin
                  pc_in    = prog_rdata_ff.jump_line;
                  state_in = S_FIN;
               end
               OP_PRINT, OP_BRANCH, OP_ASSIGN: begin
                  state_in = S_RDB;
               end
               default: begin
                  halted_in      = 1'b1;
                  pend_status_in = ST_HALT;
                  state_in       = S_FIN;
               end
            endcase
         end
         S_RDB: begin
            var_raddr = prog_rdata_ff.src_b;
            if (prog_rdata_ff.opcode == OP_PRINT) begin
               pend_status_in = ST_PRINT;
               pend_pv_in     = var_rdata_ff[31:0];
               pc_in          = pc_ff + LINE_W'(1);
               state_in       = S_FIN;
            end else begin
               x_in     = var_rdata_ff;
               state_in = S_OPS;
            end
         end
         S_OPS: begin
            if (prog_rdata_ff.opcode == OP_BRANCH) begin
               pc_in    = cmp_true ? prog_rdata_ff.jump_line : pc_ff + LINE_W'(1);
               state_in = S_FIN;
            end else begin
               wr_en_in = 1'b1;
               state_in = S_WB;
               case (prog_rdata_ff.op_select)
                  SEL_ADD: res_in = x_ff + y_val;
                  SEL_SUB: res_in = x_ff - y_val;
                  SEL_MUL: res_in = DATA_WIDTH'(x_ff * y_val);
                  SEL_DIV, SEL_MOD: begin
                     if (mag_y == '0) begin
                        halted_in      = 1'b1;
                        pend_status_in = ST_ERROR;
                        state_in       = S_FIN;
                     end else begin
                        rem_in     = '0;
                        quo_in     = mag_x;
                        divisor_in = mag_y;
                        cnt_in     = CNT_W'(DATA_WIDTH);
                        neg_in     = (prog_rdata_ff.op_select == SEL_MOD)
                                     ? x_ff[DATA_WIDTH-1]
                                     : (x_ff[DATA_WIDTH-1] ^ y_val[DATA_WIDTH-1]);
                        state_in   = S_DIV;
                     end
                  end
                  default: wr_en_in = 1'b0;
               endcase
            end
         end
         S_DIV: begin
            if (cnt_ff == '0) begin
               res_in   = neg_ff ? (~div_out + 1'b1) : div_out;
               state_in = S_WB;
            end else begin
               if (!diff[DATA_WIDTH]) begin
                  rem_in = diff[DATA_WIDTH-1:0];
                  quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh[DATA_WIDTH-1:0];
                  quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
               end
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_WB: begin
            var_we    = wr_en_ff;
            var_waddr = prog_rdata_ff.dest_var;
            var_wdata = res_ff;
            pc_in     = pc_ff + LINE_W'(1);
            state_in  = S_FIN;
         end
         S_FIN: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status:      pend_status_ff,
                                print_value: pend_pv_ff,
                                exec_line:   pend_line_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= LINE_W'(1);
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff           <= x_in;
      res_ff         <= res_in;
      wr_en_ff       <= wr_en_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      divisor_ff     <= divisor_in;
      cnt_ff         <= cnt_in;
      neg_ff         <= neg_in;
      pend_status_ff <= pend_status_in;
      pend_pv_ff     <= pend_pv_in;
      pend_line_ff   <= pend_line_in;
      rsp_data_ff    <= rsp_data_in;
   end

endmodule
